/* src/chb_pkg.sv */
// Shared types and codes for the chained hash bucket FIFO.
// Used by every module of the block; depends on nothing.
package chb_pkg;

	// Field widths fixed by the interface.
	localparam int KEY_W  = 27;
	localparam int FILL_W = 4;

	// Action codes carried in a request beat.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	// Status codes carried in a response beat.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [1:0]        status;
		logic [KEY_W-1:0]  removed_key;
		logic [FILL_W-1:0] bucket_fill;
	} rsp_t;

endpackage

/* src/chb_front.sv */
// Front end: accepts request beats, masks the key and finds its bucket.
// The bucket is key modulo BUCKETS, done by a reciprocal multiply over two stages.
// Depends on chb_pkg.
module chb_front import chb_pkg::*; #(
	parameter int BUCKETS  = 128,
	parameter int KEY_BITS = 27
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  enable,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  req_t                                  req,
	output logic                                  op_valid,
	input  logic                                  op_ready,
	output logic [2+(KEY_BITS < KEY_W ? KEY_BITS : KEY_W)+$clog2(BUCKETS)-1:0] op_data
);

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int LB = $clog2(BUCKETS);
	localparam int SH = KW + LB;
	localparam int PW = 2 * KW + 1;
	localparam int QW = KW + LB;
	localparam int DW = (KW > LB) ? KW : LB;
	localparam logic [63:0] MAGIC64 =
		((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [KW:0] MAGIC = MAGIC64[KW:0];

	logic          v_s1, v_s2;
	logic [1:0]    act_s1, act_s2;
	logic [KW-1:0] key_s1, key_s2, quo_s2;
	logic [PW-1:0] prod;
	logic [QW-1:0] qb;
	logic [DW-1:0] diff;
	logic          adv_s1, adv_s2, free_s1, free_s2;

	// Handshake between the two stages and the queue.
	assign adv_s2    = v_s2 && op_ready;
	assign free_s2   = !v_s2 || adv_s2;
	assign adv_s1    = v_s1 && free_s2;
	assign free_s1   = !v_s1 || adv_s1;
	assign req_ready = free_s1 && enable;

	// Stage one: quotient estimate by multiplying with the scaled reciprocal.
	assign prod = PW'(key_s1) * PW'(MAGIC);

	// Stage two: remainder from the quotient.
	assign qb      = QW'(quo_s2) * QW'(BUCKETS);
	assign diff    = DW'(key_s2) - qb[DW-1:0];
	assign op_valid = v_s2;
	assign op_data  = {act_s2, key_s2, diff[LB-1:0]};

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			act_s1 <= req.action;
			key_s1 <= req.key[KW-1:0];
		end
		if (adv_s1) begin
			act_s2 <= act_s1;
			key_s2 <= key_s1;
			quo_s2 <= KW'(prod >> SH);
		end
	end

endmodule

/* src/chb_queue.sv */
// Two-entry queue between the front end and the table engine.
// Self-contained; depends on chb_pkg only by house convention.
module chb_queue import chb_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

/* src/chb_back.sv */
// Table engine: reads a bucket row and its ring state, then executes the action.
// Holds the key memory and the per-bucket head/count memory. Depends on chb_pkg.
module chb_back import chb_pkg::*; #(
	parameter int BUCKETS          = 128,
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int KEY_BITS         = 27
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	output logic                                  clearing,
	input  logic                                  op_valid,
	output logic                                  op_ready,
	input  logic [2+(KEY_BITS < KEY_W ? KEY_BITS : KEY_W)+$clog2(BUCKETS)-1:0] op_data,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output rsp_t                                  rsp
);

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int LB = $clog2(BUCKETS);
	localparam int SL = SLOTS_PER_BUCKET;
	localparam int LS = (SL > 1) ? $clog2(SL) : 1;
	localparam int LC = $clog2(SL + 1);
	localparam int MW = LS + LC;

	typedef enum logic [1:0] {
		CLEAR,
		FETCH,
		EXEC
	} state_t;

	// Memories: one key row and one head/count word per bucket.
	logic [SL-1:0][KW-1:0] key_mem [BUCKETS];
	logic [MW-1:0]         meta_mem [BUCKETS];

	state_t                state_q;
	logic [LB-1:0]         clr_q;
	logic [1:0]            act_q;
	logic [KW-1:0]         key_q;
	logic [LB-1:0]         bkt_q;
	logic [SL-1:0][KW-1:0] row_q;
	logic [MW-1:0]         meta_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [1:0]    in_act;
	logic [KW-1:0] in_key;
	logic [LB-1:0] in_bkt;
	logic          take, exec_go;
	logic [LS-1:0] head, head_nx, wr_slot;
	logic [LC-1:0] cnt, cnt_nx;
	logic [LC:0]   pos_sum;
	logic          key_we, meta_we;
	logic [LB-1:0] meta_addr;
	logic [MW-1:0] meta_wd;
	logic          hit;
	logic [1:0]    status;
	logic [KW-1:0] removed;
	logic [LC:0]   off [SL];

	assign {in_act, in_key, in_bkt} = op_data;
	assign take      = (state_q == FETCH) && op_valid;
	assign op_ready  = (state_q == FETCH);
	assign exec_go   = (state_q == EXEC) && (!rsp_valid_q || rsp_ready);
	assign clearing  = (state_q == CLEAR);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign head = meta_q[MW-1:LC];
	assign cnt  = meta_q[LC-1:0];

	// Ring positions: young end for insert and the slot after the head.
	always_comb begin
		pos_sum = (LC+1)'(head) + (LC+1)'(cnt);
		if (pos_sum >= (LC+1)'(SL)) begin
			pos_sum = pos_sum - (LC+1)'(SL);
		end
		wr_slot = LS'(pos_sum);
		head_nx = (head == LS'(SL - 1)) ? '0 : head + LS'(1);
	end

	// Lookup compares every live slot of the row at once.
	always_comb begin
		hit = 1'b0;
		for (int j = 0; j < SL; j++) begin
			off[j] = (LC+1)'(j) - (LC+1)'(head);
			if ((LC+1)'(head) > (LC+1)'(j)) begin
				off[j] = off[j] + (LC+1)'(SL);
			end
			if ((off[j] < (LC+1)'(cnt)) && (row_q[j] == key_q)) begin
				hit = 1'b1;
			end
		end
	end

	// Action decode for the bucket in hand.
	always_comb begin
		status  = ST_DONE;
		removed = '0;
		cnt_nx  = cnt;
		key_we  = 1'b0;
		meta_wd = meta_q;
		case (act_q)
			ACT_INSERT: begin
				if (cnt == LC'(SL)) begin
					status = ST_FULL;
				end else begin
					key_we  = 1'b1;
					cnt_nx  = cnt + LC'(1);
					meta_wd = {head, cnt_nx};
				end
			end
			ACT_REMOVE: begin
				if (cnt == '0) begin
					status = ST_EMPTY;
				end else begin
					removed = row_q[head];
					cnt_nx  = cnt - LC'(1);
					meta_wd = {head_nx, cnt_nx};
				end
			end
			default: begin
			end
		endcase
	end

	// Memory write port: the clearing sweep or the write-back of an action.
	always_comb begin
		meta_we   = 1'b0;
		meta_addr = bkt_q;
		if (state_q == CLEAR) begin
			meta_we   = 1'b1;
			meta_addr = clr_q;
		end else if (exec_go) begin
			meta_we = 1'b1;
		end
	end

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_addr] <= (state_q == CLEAR) ? '0 : meta_wd;
		end
		if (exec_go && key_we) begin
			key_mem[bkt_q][wr_slot] <= key_q;
		end
		if (take) begin
			row_q  <= key_mem[in_bkt];
			meta_q <= meta_mem[in_bkt];
		end
	end

	// Sequencer: clear after reset, then fetch and execute one action at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + LB'(1);
					if (clr_q == LB'(BUCKETS - 1)) begin
						state_q <= FETCH;
					end
				end
				FETCH: begin
					if (take) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (exec_go) begin
						rsp_valid_q <= 1'b1;
						state_q     <= FETCH;
					end
				end
				default: begin
					state_q <= FETCH;
				end
			endcase
		end
	end

	// Captured action and response payload.
	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= in_act;
			key_q <= in_key;
			bkt_q <= in_bkt;
		end
		if (exec_go) begin
			rsp_q.found       <= (act_q == ACT_LOOKUP) && hit;
			rsp_q.status      <= status;
			rsp_q.removed_key <= KEY_W'(removed);
			rsp_q.bucket_fill <= FILL_W'(cnt_nx);
		end
	end

endmodule

/* src/chained_hash_bucket_fifo_top.sv */
// Top level of the chained hash bucket FIFO: front end, queue and table engine.
// Depends on chb_pkg, chb_front, chb_queue and chb_back.
//
//  Channel | Direction | Handshake              | Beat
//  req     | in        | req_valid / req_ready  | req_t: action, key
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_t: found, status, removed_key, bucket_fill
//
// In the table engine each request is read in FETCH (the bucket row and its head/count
// word) and then executed and written back in EXEC. The front end computes the bucket
// remainder in its stage one and stage two registers. After reset a sweep clears the
// head/count memory of every bucket; no request is taken meanwhile. A stalled
// response holds the engine, and the queue and front end absorb up to four beats.
module chained_hash_bucket_fifo_top import chb_pkg::*; #(
	parameter int BUCKETS          = 128,
	parameter int SLOTS_PER_BUCKET = 8,
	parameter int KEY_BITS         = 27
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int OW = 2 + KW + $clog2(BUCKETS);

	logic          clearing;
	logic          f_valid, f_ready, b_valid, b_ready;
	logic [OW-1:0] f_data, b_data;

	// Bucket selection.
	chb_front #(
		.BUCKETS  (BUCKETS),
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (!clearing),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op_data   (f_data)
	);

	// Decoupling queue.
	chb_queue #(
		.WIDTH (OW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	// Bucket storage and execution.
	chb_back #(
		.BUCKETS          (BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.KEY_BITS         (KEY_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op_data   (b_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
